// ----- rtl/cbrd_pkg.sv -----
// shared constants, types and field helpers for the complex-by-real binary32 divider
`default_nettype none
package cbrd_pkg;

  localparam int EXP_BITS = 8;
  localparam int FRAC_BITS = 23;
  localparam int WORD_W = EXP_BITS + FRAC_BITS + 1;
  localparam int SIG_W = FRAC_BITS + 1;
  localparam int BIAS = (1 << (EXP_BITS - 1)) - 1;
  localparam int EXP_ALL = (1 << EXP_BITS) - 1;
  localparam int LSB_W = EXP_BITS + 4;
  localparam int LZ_W = $clog2(FRAC_BITS + 1);
  localparam int MIN_LSB = 1 - BIAS - FRAC_BITS;
  localparam int QUO_W = FRAC_BITS + 5;
  localparam int PROD_W = 2 * SIG_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [LSB_W-1:0] lsb_t;
  typedef logic [LZ_W-1:0] lz_t;
  typedef logic [SIG_W-1:0] sig_t;

  localparam word_t INF_BITS = word_t'(EXP_ALL) << FRAC_BITS;
  localparam word_t QUIET_BIT = word_t'(1) << (FRAC_BITS - 1);
  localparam word_t CANON_NAN = INF_BITS | QUIET_BIT;

  function automatic logic [EXP_BITS-1:0] exp_of(word_t x);
    return x[WORD_W-2:FRAC_BITS];
  endfunction

  function automatic logic is_nan(word_t x);
    return (&exp_of(x)) && (|x[FRAC_BITS-1:0]);
  endfunction

  function automatic logic is_inf(word_t x);
    return (&exp_of(x)) && !(|x[FRAC_BITS-1:0]);
  endfunction

  function automatic logic is_zero(word_t x);
    return !(|x[WORD_W-2:0]);
  endfunction

  // left shift that brings a subnormal fraction up to the hidden bit
  function automatic lz_t lead_shift(logic [FRAC_BITS-1:0] f);
    lz_t n;
    n = lz_t'(FRAC_BITS);
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (f[i]) n = lz_t'(FRAC_BITS - i);
    end
    return n;
  endfunction

  function automatic sig_t unpack_sig(word_t x, lz_t lz);
    if (exp_of(x) == '0) return sig_t'({1'b0, x[FRAC_BITS-1:0]}) << lz;
    return {1'b1, x[FRAC_BITS-1:0]};
  endfunction

  function automatic lsb_t unpack_lsb(word_t x, lz_t lz);
    if (exp_of(x) == '0) return lsb_t'(MIN_LSB) - lsb_t'(lz);
    return lsb_t'(exp_of(x)) - lsb_t'(BIAS + FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cbrd_round.sv -----
// three-stage round-to-nearest-even and pack of a significand with exponent
`default_nettype none
module cbrd_round #(
  parameter int IN_W = cbrd_pkg::PROD_W,
  parameter int PASS_W = 1
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       en,
  input  wire                       in_valid,
  input  wire                       in_sign,
  input  wire cbrd_pkg::lsb_t       in_lsb,
  input  wire [IN_W-1:0]            in_sig,
  input  wire                       in_sticky,
  input  wire [PASS_W-1:0]          in_pass,
  output logic                      out_valid,
  output cbrd_pkg::word_t           out_word,
  output logic [PASS_W-1:0]         out_pass
);

  localparam int F = cbrd_pkg::FRAC_BITS;
  localparam int SIG_W = cbrd_pkg::SIG_W;
  localparam int LSB_W = cbrd_pkg::LSB_W;
  localparam int EXP_BITS = cbrd_pkg::EXP_BITS;
  localparam int WORD_W = cbrd_pkg::WORD_W;
  localparam int SH_W = $clog2(IN_W + 2);

  typedef logic signed [LSB_W:0] xl_t;

  // stage 1: shift amount
  xl_t lsb_x, sub, nsh_x;
  logic [SH_W-1:0] nsh, sh;

  always_comb begin
    lsb_x = {in_lsb[LSB_W-1], in_lsb};
    sub = xl_t'(cbrd_pkg::MIN_LSB) - lsb_x;
    nsh = in_sig[IN_W-1] ? SH_W'(IN_W - SIG_W) : SH_W'(IN_W - SIG_W - 1);
    nsh_x = xl_t'(nsh);
    if (sub > xl_t'(IN_W + 1)) begin
      sh = SH_W'(IN_W + 1);
    end else if (sub > nsh_x) begin
      sh = sub[SH_W-1:0];
    end else begin
      sh = nsh;
    end
  end

  logic r1_valid, r1_sign, r1_sticky;
  xl_t r1_lsb;
  logic [SH_W-1:0] r1_sh;
  logic [IN_W-1:0] r1_sig;
  logic [PASS_W-1:0] r1_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sign <= in_sign;
      r1_lsb <= lsb_x + xl_t'(sh);
      r1_sh <= sh;
      r1_sig <= in_sig;
      r1_sticky <= in_sticky;
      r1_pass <= in_pass;
    end
  end

  // stage 2: alignment shift, guard and sticky
  logic [2*IN_W-1:0] wide;
  logic [IN_W-1:0] kept, low;

  always_comb begin
    wide = {r1_sig, IN_W'(0)} >> r1_sh;
    kept = wide[2*IN_W-1:IN_W];
    low = wide[IN_W-1:0];
  end

  logic r2_valid, r2_sign, r2_guard, r2_rest;
  xl_t r2_lsb;
  logic [SIG_W-1:0] r2_kept;
  logic [PASS_W-1:0] r2_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (en) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_sign <= r1_sign;
      r2_lsb <= r1_lsb;
      r2_kept <= kept[SIG_W-1:0];
      r2_guard <= low[IN_W-1];
      r2_rest <= (|low[IN_W-2:0]) | r1_sticky;
      r2_pass <= r1_pass;
    end
  end

  // stage 3: increment and pack
  logic inc;
  logic [SIG_W:0] s2;
  logic [SIG_W-1:0] s3;
  xl_t l3, biased;
  cbrd_pkg::word_t word;

  always_comb begin
    inc = r2_guard & (r2_rest | r2_kept[0]);
    s2 = {1'b0, r2_kept} + (SIG_W+1)'(inc);
    if (s2[SIG_W]) begin
      s3 = s2[SIG_W:1];
      l3 = r2_lsb + xl_t'(1);
    end else begin
      s3 = s2[SIG_W-1:0];
      l3 = r2_lsb;
    end
    biased = l3 + xl_t'(F + cbrd_pkg::BIAS);
    if (!s3[SIG_W-1]) begin
      word = {r2_sign, EXP_BITS'(0), s3[F-1:0]};
    end else if (biased >= xl_t'(cbrd_pkg::EXP_ALL)) begin
      word = {r2_sign, cbrd_pkg::INF_BITS[WORD_W-2:0]};
    end else begin
      word = {r2_sign, biased[EXP_BITS-1:0], s3[F-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word;
      out_pass <= r2_pass;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cbrd_recip.sv -----
// pipelined reciprocal: unpack, one quotient bit per stage, round
`default_nettype none
module cbrd_recip #(
  parameter int PASS_W = 1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire cbrd_pkg::word_t in_divisor,
  input  wire [PASS_W-1:0]     in_pass,
  output logic                 out_valid,
  output cbrd_pkg::word_t      out_recip,
  output logic [PASS_W-1:0]    out_pass
);

  localparam int F = cbrd_pkg::FRAC_BITS;
  localparam int SIG_W = cbrd_pkg::SIG_W;
  localparam int QUO_W = cbrd_pkg::QUO_W;
  localparam int WORD_W = cbrd_pkg::WORD_W;

  // unpack stage 1: normalize count
  logic u1_valid;
  cbrd_pkg::word_t u1_x;
  cbrd_pkg::lz_t u1_lz;
  logic [PASS_W-1:0] u1_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      u1_valid <= 1'b0;
    end else if (en) begin
      u1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_x <= in_divisor;
      u1_lz <= cbrd_pkg::lead_shift(in_divisor[F-1:0]);
      u1_pass <= in_pass;
    end
  end

  // divider stages, index 0 is the unpacked divisor
  logic d_valid [QUO_W+1];
  logic d_sign [QUO_W+1];
  cbrd_pkg::sig_t d_m [QUO_W+1];
  cbrd_pkg::sig_t d_rem [QUO_W+1];
  logic [QUO_W-1:0] d_q [QUO_W+1];
  cbrd_pkg::lsb_t d_lsb [QUO_W+1];
  logic [PASS_W-1:0] d_pass [QUO_W+1];

  cbrd_pkg::lsb_t u1_p;

  always_comb begin
    u1_p = cbrd_pkg::unpack_lsb(u1_x, u1_lz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= u1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sign[0] <= u1_x[WORD_W-1];
      d_m[0] <= cbrd_pkg::unpack_sig(u1_x, u1_lz);
      d_rem[0] <= SIG_W'(1) << (F - 1);
      d_q[0] <= '0;
      d_lsb[0] <= cbrd_pkg::lsb_t'(0) - u1_p - cbrd_pkg::lsb_t'(2 * F + 4);
      d_pass[0] <= u1_pass;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [SIG_W:0] shifted;
    logic [SIG_W+1:0] diff;

    always_comb begin
      shifted = {d_rem[k-1], 1'b0};
      diff = {1'b0, shifted} - {2'b00, d_m[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k] <= 1'b0;
      end else if (en) begin
        d_valid[k] <= d_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k] <= diff[SIG_W+1] ? shifted[SIG_W-1:0] : diff[SIG_W-1:0];
        d_q[k] <= {d_q[k-1][QUO_W-2:0], ~diff[SIG_W+1]};
        d_sign[k] <= d_sign[k-1];
        d_m[k] <= d_m[k-1];
        d_lsb[k] <= d_lsb[k-1];
        d_pass[k] <= d_pass[k-1];
      end
    end
  end

  cbrd_round #(
    .IN_W   (QUO_W),
    .PASS_W (PASS_W)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid[QUO_W]),
    .in_sign   (d_sign[QUO_W]),
    .in_lsb    (d_lsb[QUO_W]),
    .in_sig    (d_q[QUO_W]),
    .in_sticky (|d_rem[QUO_W]),
    .in_pass   (d_pass[QUO_W]),
    .out_valid (out_valid),
    .out_word  (out_recip),
    .out_pass  (out_pass)
  );

endmodule
`default_nettype wire

// ----- rtl/cbrd_mul.sv -----
// two-lane pipelined binary32 multiply of the dividend parts by the reciprocal
`default_nettype none
module cbrd_mul #(
  parameter int PASS_W = 1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire cbrd_pkg::word_t in_re,
  input  wire cbrd_pkg::word_t in_im,
  input  wire cbrd_pkg::word_t in_recip,
  input  wire [PASS_W-1:0]     in_pass,
  output logic                 out_valid,
  output cbrd_pkg::word_t      out_re,
  output cbrd_pkg::word_t      out_im,
  output logic [PASS_W-1:0]    out_pass
);

  localparam int F = cbrd_pkg::FRAC_BITS;
  localparam int WORD_W = cbrd_pkg::WORD_W;
  localparam int PROD_W = cbrd_pkg::PROD_W;

  cbrd_pkg::word_t a_in [2];
  logic spec [2];
  cbrd_pkg::word_t spec_val [2];

  always_comb begin
    a_in[0] = in_re;
    a_in[1] = in_im;
    for (int l = 0; l < 2; l++) begin
      spec[l] = 1'b1;
      spec_val[l] = '0;
      if (cbrd_pkg::is_nan(a_in[l])) begin
        spec_val[l] = a_in[l] | cbrd_pkg::QUIET_BIT;
      end else if (cbrd_pkg::is_inf(a_in[l])) begin
        spec_val[l] = cbrd_pkg::is_zero(in_recip) ? cbrd_pkg::CANON_NAN :
          {a_in[l][WORD_W-1] ^ in_recip[WORD_W-1], cbrd_pkg::INF_BITS[WORD_W-2:0]};
      end else if (cbrd_pkg::is_inf(in_recip)) begin
        spec_val[l] = cbrd_pkg::is_zero(a_in[l]) ? cbrd_pkg::CANON_NAN :
          {a_in[l][WORD_W-1] ^ in_recip[WORD_W-1], cbrd_pkg::INF_BITS[WORD_W-2:0]};
      end else if (cbrd_pkg::is_zero(a_in[l]) || cbrd_pkg::is_zero(in_recip)) begin
        spec_val[l] = {a_in[l][WORD_W-1] ^ in_recip[WORD_W-1], (WORD_W-1)'(0)};
      end else begin
        spec[l] = 1'b0;
      end
    end
  end

  // stage 1: normalize counts and special results
  logic m1_valid;
  cbrd_pkg::word_t m1_a [2];
  cbrd_pkg::lz_t m1_lza [2];
  cbrd_pkg::word_t m1_r;
  cbrd_pkg::lz_t m1_lzr;
  logic m1_spec [2];
  cbrd_pkg::word_t m1_val [2];
  logic [PASS_W-1:0] m1_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        m1_a[l] <= a_in[l];
        m1_lza[l] <= cbrd_pkg::lead_shift(a_in[l][F-1:0]);
        m1_spec[l] <= spec[l];
        m1_val[l] <= spec_val[l];
      end
      m1_r <= in_recip;
      m1_lzr <= cbrd_pkg::lead_shift(in_recip[F-1:0]);
      m1_pass <= in_pass;
    end
  end

  // stage 2: unpacked significands and exponents
  logic m2_valid;
  cbrd_pkg::sig_t m2_sa [2];
  cbrd_pkg::lsb_t m2_la [2];
  logic m2_sign [2];
  cbrd_pkg::sig_t m2_sr;
  cbrd_pkg::lsb_t m2_lr;
  logic m2_spec [2];
  cbrd_pkg::word_t m2_val [2];
  logic [PASS_W-1:0] m2_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        m2_sa[l] <= cbrd_pkg::unpack_sig(m1_a[l], m1_lza[l]);
        m2_la[l] <= cbrd_pkg::unpack_lsb(m1_a[l], m1_lza[l]);
        m2_sign[l] <= m1_a[l][WORD_W-1] ^ m1_r[WORD_W-1];
        m2_spec[l] <= m1_spec[l];
        m2_val[l] <= m1_val[l];
      end
      m2_sr <= cbrd_pkg::unpack_sig(m1_r, m1_lzr);
      m2_lr <= cbrd_pkg::unpack_lsb(m1_r, m1_lzr);
      m2_pass <= m1_pass;
    end
  end

  // stage 3: products
  logic m3_valid;
  logic [PROD_W-1:0] m3_prod [2];
  cbrd_pkg::lsb_t m3_lsb [2];
  logic m3_sign [2];
  logic m3_spec [2];
  cbrd_pkg::word_t m3_val [2];
  logic [PASS_W-1:0] m3_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (en) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        m3_prod[l] <= m2_sa[l] * m2_sr;
        m3_lsb[l] <= m2_la[l] + m2_lr;
        m3_sign[l] <= m2_sign[l];
        m3_spec[l] <= m2_spec[l];
        m3_val[l] <= m2_val[l];
      end
      m3_pass <= m2_pass;
    end
  end

  cbrd_pkg::word_t rnd_re, rnd_im, val_re, val_im;
  logic spec_re, spec_im;

  cbrd_round #(
    .IN_W   (PROD_W),
    .PASS_W (PASS_W + 1 + WORD_W)
  ) u_round_re (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m3_valid),
    .in_sign   (m3_sign[0]),
    .in_lsb    (m3_lsb[0]),
    .in_sig    (m3_prod[0]),
    .in_sticky (1'b0),
    .in_pass   ({m3_pass, m3_spec[0], m3_val[0]}),
    .out_valid (out_valid),
    .out_word  (rnd_re),
    .out_pass  ({out_pass, spec_re, val_re})
  );

  cbrd_round #(
    .IN_W   (PROD_W),
    .PASS_W (1 + WORD_W)
  ) u_round_im (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m3_valid),
    .in_sign   (m3_sign[1]),
    .in_lsb    (m3_lsb[1]),
    .in_sig    (m3_prod[1]),
    .in_sticky (1'b0),
    .in_pass   ({m3_spec[1], m3_val[1]}),
    .out_valid (),
    .out_word  (rnd_im),
    .out_pass  ({spec_im, val_im})
  );

  assign out_re = spec_re ? val_re : rnd_re;
  assign out_im = spec_im ? val_im : rnd_im;

endmodule
`default_nettype wire

// ----- rtl/complex_by_real_divide_fp32.sv -----
// top level: binary32 complex number divided by a real divisor, one item per clock unless stalled
//
// input stream s_axis: one transfer carries the dividend's real and imaginary
// parts and the real divisor, all binary32 bit patterns. output stream m_axis:
// one transfer per input with the real and imaginary quotients.
// the divisor's reciprocal is formed first (rounded to nearest even), then
// multiplied into both parts with a second rounding. an infinite divisor gives
// the divisor itself and +infinity; a nan or zero divisor gives the quiet nan.
// the delay from the accepting edge to tvalid on m_axis is set by the
// restoring reciprocal divider, one quotient bit per stage (28 stages),
// plus unpack, multiply and two rounding pipelines.
// throughput: one transfer per clock while s_axis_tready is high.
// reset clears every valid bit; the block then takes input at once.
// when the receiver stalls, an output register and a one-entry skid buffer
// hold results; s_axis_tready drops only once the skid buffer is full, and
// the whole pipeline then holds, losing and repeating nothing.
`default_nettype none
module complex_by_real_divide_fp32 (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // real_part, imag_part, divisor
  input  wire [3*cbrd_pkg::WORD_W-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // real_quotient, imag_quotient
  output logic [2*cbrd_pkg::WORD_W-1:0]      m_axis_tdata
);

  localparam int WORD_W = cbrd_pkg::WORD_W;
  localparam int RPASS_W = 1 + 4 * WORD_W;
  localparam int MPASS_W = 1 + 2 * WORD_W;

  cbrd_pkg::word_t in_re, in_im, in_div, sp_re, sp_im;
  logic sp;
  logic en;

  assign in_re = s_axis_tdata[WORD_W-1:0];
  assign in_im = s_axis_tdata[2*WORD_W-1:WORD_W];
  assign in_div = s_axis_tdata[3*WORD_W-1:2*WORD_W];

  always_comb begin
    sp = 1'b1;
    sp_re = cbrd_pkg::CANON_NAN;
    sp_im = cbrd_pkg::CANON_NAN;
    if (cbrd_pkg::is_inf(in_div)) begin
      sp_re = in_div;
      sp_im = cbrd_pkg::INF_BITS;
    end else if (!cbrd_pkg::is_nan(in_div) && !cbrd_pkg::is_zero(in_div)) begin
      sp = 1'b0;
    end
  end

  logic r_valid;
  cbrd_pkg::word_t r_word;
  logic [RPASS_W-1:0] r_pass;

  cbrd_recip #(
    .PASS_W (RPASS_W)
  ) u_recip (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid & s_axis_tready),
    .in_divisor (in_div),
    .in_pass    ({sp, sp_re, sp_im, in_im, in_re}),
    .out_valid  (r_valid),
    .out_recip  (r_word),
    .out_pass   (r_pass)
  );

  logic q_valid;
  cbrd_pkg::word_t q_re, q_im, f_re, f_im;
  logic [MPASS_W-1:0] q_pass;

  cbrd_mul #(
    .PASS_W (MPASS_W)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_re     (r_pass[WORD_W-1:0]),
    .in_im     (r_pass[2*WORD_W-1:WORD_W]),
    .in_recip  (r_word),
    .in_pass   (r_pass[RPASS_W-1:2*WORD_W]),
    .out_valid (q_valid),
    .out_re    (q_re),
    .out_im    (q_im),
    .out_pass  (q_pass)
  );

  assign f_re = q_pass[MPASS_W-1] ? q_pass[2*WORD_W-1:WORD_W] : q_re;
  assign f_im = q_pass[MPASS_W-1] ? q_pass[WORD_W-1:0] : q_im;

  // output register with skid buffer
  logic skid_valid;
  logic [2*WORD_W-1:0] skid;

  assign en = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= q_valid;
      end
    end else if (q_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= skid_valid ? skid : {f_im, f_re};
    end else if (q_valid && en) begin
      skid <= {f_im, f_re};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cbrd_check.sv -----
// port-level checker for the complex-by-real divider, bound to the top level
`default_nettype none
module cbrd_check (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [95:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input blocked without output stall");

endmodule

bind complex_by_real_divide_fp32 cbrd_check u_cbrd_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
